// ----- rtl/triangle_near_clip_project_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the near-plane clip and projection core
// Concurrent checks, sampled on the rising clock edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NEAR_CLIP_PROJECT_CORE_DEFINES_SVH
`define TRIANGLE_NEAR_CLIP_PROJECT_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent
`define TNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent
`define TNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tnc_pkg.sv -----
// ----------------------------------------------------------------------------
// tnc_pkg
// Types, register codes and constants shared by the clip and projection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tnc_pkg;

    localparam int TNC_QUEUE_DEPTH = 2;
    localparam int CFG_DATA_W      = 31;
    localparam int CFG_INDEX_W     = 3;
    localparam int FRAC_W          = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_Z       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_LEFT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_TOP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_HEIGHT  = 3'd5;

    // Vertex component codes
    localparam logic [2:0] COMP_X = 3'd0;
    localparam logic [2:0] COMP_Y = 3'd1;
    localparam logic [2:0] COMP_Z = 3'd2;
    localparam logic [2:0] COMP_U = 3'd3;
    localparam logic [2:0] COMP_V = 3'd4;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         texel_u;
        logic [7:0]         texel_v;
    } vtx_in_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [16:0]        inverse_depth;
        logic [23:0]        out_u;
        logic [23:0]        out_v;
        logic [1:0]         corner;
        logic               last_of_run;
    } vtx_out_t;

    // One collected triangle and which of its corners lie on the visible side
    typedef struct packed {
        vtx_in_t    v0;
        vtx_in_t    v1;
        vtx_in_t    v2;
        logic [2:0] in_mask;
    } tri_t;

    typedef struct packed {
        logic [30:0] near_z;
        logic [30:0] focal_length;
        logic [12:0] center_x;
        logic [12:0] center_y;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EDGE,
        BK_MUL,
        BK_GO,
        BK_WAIT,
        BK_FAN,
        BK_EMIT
    } bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/tnc_front.sv -----
// ----------------------------------------------------------------------------
// tnc_front
// Collects three vertices, marks each against the near plane and queues the
// triangle. Triangles with no visible corner are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnc_front
    import tnc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    vert_valid,
    output logic         vert_ready,
    input  wire vtx_in_t vert,
    input  wire logic    q_full,
    output logic         q_push,
    output tri_t         q_data
);

    logic [1:0]  count_reg;
    vtx_in_t     h0_reg;
    vtx_in_t     h1_reg;
    logic [2:0]  mask;
    logic        accept;
    logic signed [32:0] nz;

    // Classify each corner: visible when z >= near_z
    assign nz      = $signed({2'b00, cfg.near_z});
    assign mask[0] = $signed({h0_reg.pos_z[31], h0_reg.pos_z}) >= nz;
    assign mask[1] = $signed({h1_reg.pos_z[31], h1_reg.pos_z}) >= nz;
    assign mask[2] = $signed({vert.pos_z[31], vert.pos_z}) >= nz;

    assign vert_ready = (count_reg != 2'd2) || !q_full;
    assign accept     = vert_valid && vert_ready;
    assign q_push     = accept && (count_reg == 2'd2) && (mask != 3'b000);

    always_comb
    begin
        q_data.v0      = h0_reg;
        q_data.v1      = h1_reg;
        q_data.v2      = vert;
        q_data.in_mask = mask;
    end

    // Advance the corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
        end
    end

    // Hold the first two corners
    always_ff @(posedge clk)
    begin
        if (accept && (count_reg == 2'd0))
        begin
            h0_reg <= vert;
        end
        if (accept && (count_reg == 2'd1))
        begin
            h1_reg <= vert;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tnc_queue.sv -----
// ----------------------------------------------------------------------------
// tnc_queue
// Small triangle queue between the classifier and the clip sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnc_queue
    import tnc_pkg::*;
#(
    parameter int DEPTH = TNC_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire tri_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output tri_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tri_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the pushed triangle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tnc_div.sv -----
// ----------------------------------------------------------------------------
// tnc_div
// Restoring unsigned divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnc_div
    import tnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [63:0] quo_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial    = {rem_reg, quo_reg[63]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Count iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 7'd1);
            if (start)
            begin
                cnt_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 7'd1;
                busy_reg <= (cnt_reg != 7'd1);
            end
        end
    end

    // Shift in one dividend bit and subtract where the divisor fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tnc_back.sv -----
// ----------------------------------------------------------------------------
// tnc_back
// Clips a queued triangle against the near plane, projects the remaining
// corners through the shared divider and emits the fan vertices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_near_clip_project_core_defines.svh"

module tnc_back
    import tnc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    input  wire tri_t head,
    output logic      q_pop,
    output logic      pix_valid,
    input  wire logic pix_ready,
    output vtx_out_t  pix
);

    bk_state_t   state_reg;
    bk_state_t   state_next;
    logic [1:0]  e_reg;
    logic [2:0]  n_reg;
    logic [1:0]  p_reg;
    logic [2:0]  comp_reg;
    logic        proj_reg;
    logic [1:0]  fan_reg;
    logic [1:0]  corner_reg;
    logic        pix_valid_reg;
    vtx_out_t    pix_reg;

    logic [31:0] px_reg [4];
    logic [31:0] py_reg [4];
    logic [31:0] pz_reg [4];
    logic [23:0] pu_reg [4];
    logic [23:0] pv_reg [4];
    logic [31:0] sx_reg [4];
    logic [31:0] sy_reg [4];
    logic [16:0] iz_reg [4];

    logic [63:0] dividend_reg;
    logic [31:0] divisor_reg;
    logic        neg_reg;
    logic [31:0] base_reg;

    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_quo;

    logic [1:0]  e1;
    vtx_in_t     va;
    vtx_in_t     vb;
    logic        ain;
    logic        bin;
    logic        crosses;
    logic signed [33:0] ca;
    logic signed [33:0] cb;
    logic signed [33:0] za;
    logic signed [33:0] zb;
    logic signed [33:0] d;
    logic signed [33:0] num;
    logic signed [33:0] den;
    logic [33:0] d_mag;
    logic [33:0] num_mag;
    logic [33:0] den_mag;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] zpos;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;
    logic [63:0] op_dividend;
    logic [31:0] op_divisor;
    logic        op_neg;
    logic [31:0] op_base;
    logic [2:0]  last_comp;
    logic [31:0] res;
    logic        load_pix;
    logic [1:0]  sel;
    logic        fan_last;

    function automatic vtx_in_t vsel(input tri_t t, input logic [1:0] i);
        vtx_in_t r;
        case (i)
            2'd1:    r = t.v1;
            2'd2:    r = t.v2;
            default: r = t.v0;
        endcase
        return r;
    endfunction

    function automatic logic signed [33:0] comp_val(input vtx_in_t v, input logic [2:0] c);
        logic signed [33:0] r;
        case (c)
            COMP_X:  r = $signed({{2{v.pos_x[31]}}, v.pos_x});
            COMP_Y:  r = $signed({{2{v.pos_y[31]}}, v.pos_y});
            COMP_Z:  r = $signed({{2{v.pos_z[31]}}, v.pos_z});
            COMP_U:  r = $signed({10'd0, v.texel_u, 16'd0});
            default: r = $signed({10'd0, v.texel_v, 16'd0});
        endcase
        return r;
    endfunction

    tnc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Edge operands for the clip
    assign e1      = (e_reg == 2'd2) ? 2'd0 : e_reg + 2'd1;
    assign va      = vsel(head, e_reg);
    assign vb      = vsel(head, e1);
    assign ain     = head.in_mask[e_reg];
    assign bin     = head.in_mask[e1];
    assign crosses = ain != bin;
    assign ca    = comp_val(va, comp_reg);
    assign cb    = comp_val(vb, comp_reg);
    assign za    = comp_val(va, COMP_Z);
    assign zb    = comp_val(vb, COMP_Z);
    assign d     = cb - ca;
    assign num   = $signed({3'd0, cfg.near_z}) - za;
    assign den   = zb - za;
    assign d_mag   = d[33]   ? 34'(-d)   : d;
    assign num_mag = num[33] ? 34'(-num) : num;
    assign den_mag = den[33] ? 34'(-den) : den;

    // Corner operands for the projection
    assign vx   = px_reg[p_reg];
    assign vy   = py_reg[p_reg];
    assign vz   = pz_reg[p_reg];
    assign zpos = (!vz[31] && (vz != 32'd0)) ? vz : 32'd1;

    // Select multiplier inputs, divider operands and the sign of the step
    always_comb
    begin
        if (!proj_reg)
        begin
            ma         = d_mag[31:0];
            mb         = num_mag[31:0];
            op_divisor = den_mag[31:0];
            op_neg     = d[33] ^ num[33] ^ den[33];
            op_base    = ca[31:0];
        end
        else if (comp_reg == COMP_X)
        begin
            ma         = vx[31] ? 32'(-vx) : vx;
            mb         = {1'b0, cfg.focal_length};
            op_divisor = zpos;
            op_neg     = vx[31];
            op_base    = {3'd0, cfg.center_x, 16'd0};
        end
        else if (comp_reg == COMP_Y)
        begin
            ma         = vy[31] ? 32'(-vy) : vy;
            mb         = {1'b0, cfg.focal_length};
            op_divisor = zpos;
            op_neg     = !vy[31];
            op_base    = {3'd0, cfg.center_y, 16'd0};
        end
        else
        begin
            ma         = 32'd0;
            mb         = 32'd0;
            op_divisor = zpos;
            op_neg     = 1'b0;
            op_base    = 32'd0;
        end
        prod = ma * mb;
        if (proj_reg && (comp_reg == COMP_Z))
        begin
            op_dividend = {17'd0, cfg.near_z, 16'd0};
        end
        else
        begin
            op_dividend = prod;
        end
    end

    assign last_comp = proj_reg ? COMP_Z : COMP_V;
    assign res       = base_reg + (neg_reg ? 32'(-div_quo[31:0]) : div_quo[31:0]);
    assign sel       = (corner_reg == 2'd0) ? 2'd0 : 2'(fan_reg + corner_reg - 2'd1);
    assign fan_last  = ({1'b0, fan_reg} + 3'd2) == n_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_EDGE;
                end
            end
            BK_EDGE:
            begin
                if (crosses)
                begin
                    state_next = BK_MUL;
                end
                else if (e_reg == 2'd2)
                begin
                    state_next = BK_FAN;
                end
            end
            BK_MUL:
            begin
                state_next = BK_GO;
            end
            BK_GO:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (div_done)
                begin
                    if (comp_reg != last_comp)
                    begin
                        state_next = BK_MUL;
                    end
                    else if (!proj_reg)
                    begin
                        state_next = (e_reg == 2'd2) ? BK_FAN : BK_EDGE;
                    end
                    else
                    begin
                        state_next = (p_reg == 2'(n_reg - 3'd1)) ? BK_EMIT : BK_MUL;
                    end
                end
            end
            BK_FAN:
            begin
                state_next = (n_reg < 3'd3) ? BK_IDLE : BK_MUL;
            end
            BK_EMIT:
            begin
                if (load_pix && (corner_reg == 2'd2) && fan_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        div_start = (state_reg == BK_GO);
        q_pop     = (state_reg == BK_FAN);
        load_pix  = (state_reg == BK_EMIT) && (!pix_valid_reg || pix_ready);
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // Sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            e_reg         <= 2'd0;
            n_reg         <= 3'd0;
            p_reg         <= 2'd0;
            comp_reg      <= 3'd0;
            proj_reg      <= 1'b0;
            fan_reg       <= 2'd1;
            corner_reg    <= 2'd0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == BK_IDLE) && q_valid)
            begin
                e_reg    <= 2'd0;
                n_reg    <= 3'd0;
                proj_reg <= 1'b0;
            end
            if (state_reg == BK_EDGE)
            begin
                if (ain)
                begin
                    n_reg <= n_reg + 3'd1;
                end
                if (crosses)
                begin
                    comp_reg <= COMP_X;
                end
                else if (e_reg != 2'd2)
                begin
                    e_reg <= e_reg + 2'd1;
                end
            end
            if ((state_reg == BK_WAIT) && div_done)
            begin
                if (comp_reg == last_comp)
                begin
                    comp_reg <= COMP_X;
                    if (!proj_reg)
                    begin
                        n_reg <= n_reg + 3'd1;
                        if (e_reg != 2'd2)
                        begin
                            e_reg <= e_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        p_reg <= p_reg + 2'd1;
                    end
                end
                else
                begin
                    comp_reg <= comp_reg + 3'd1;
                end
            end
            if (state_reg == BK_FAN)
            begin
                proj_reg   <= 1'b1;
                p_reg      <= 2'd0;
                comp_reg   <= COMP_X;
                fan_reg    <= 2'd1;
                corner_reg <= 2'd0;
            end
            if (load_pix)
            begin
                pix_valid_reg <= 1'b1;
                if (corner_reg == 2'd2)
                begin
                    corner_reg <= 2'd0;
                    fan_reg    <= fan_reg + 2'd1;
                end
                else
                begin
                    corner_reg <= corner_reg + 2'd1;
                end
            end
            else if (pix_ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    // Polygon, projection and divider operand storage
    always_ff @(posedge clk)
    begin
        if ((state_reg == BK_EDGE) && ain)
        begin
            px_reg[n_reg[1:0]] <= va.pos_x;
            py_reg[n_reg[1:0]] <= va.pos_y;
            pz_reg[n_reg[1:0]] <= va.pos_z;
            pu_reg[n_reg[1:0]] <= {va.texel_u, 16'd0};
            pv_reg[n_reg[1:0]] <= {va.texel_v, 16'd0};
        end
        if (state_reg == BK_MUL)
        begin
            dividend_reg <= op_dividend;
            divisor_reg  <= op_divisor;
            neg_reg      <= op_neg;
            base_reg     <= op_base;
        end
        if ((state_reg == BK_WAIT) && div_done)
        begin
            if (!proj_reg)
            begin
                unique case (comp_reg)
                    COMP_X:  px_reg[n_reg[1:0]] <= res;
                    COMP_Y:  py_reg[n_reg[1:0]] <= res;
                    COMP_Z:  pz_reg[n_reg[1:0]] <= res;
                    COMP_U:  pu_reg[n_reg[1:0]] <= res[23:0];
                    default: pv_reg[n_reg[1:0]] <= res[23:0];
                endcase
            end
            else
            begin
                unique case (comp_reg)
                    COMP_X:  sx_reg[p_reg] <= res;
                    COMP_Y:  sy_reg[p_reg] <= res;
                    default: iz_reg[p_reg] <= div_quo[16:0];
                endcase
            end
        end
        if (load_pix)
        begin
            pix_reg.screen_x      <= sx_reg[sel];
            pix_reg.screen_y      <= sy_reg[sel];
            pix_reg.inverse_depth <= iz_reg[sel];
            pix_reg.out_u         <= pu_reg[sel];
            pix_reg.out_v         <= pv_reg[sel];
            pix_reg.corner        <= corner_reg;
            pix_reg.last_of_run   <= (corner_reg == 2'd2) && fan_last;
        end
    end

    // Checks
    `TNC_ASSERT_NOW(a_start_idle, clk, rst_n, div_start, !div_busy, "divider started while busy")
    `TNC_ASSERT_NOW(a_pop_valid, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `TNC_ASSERT_NOW(a_emit_count, clk, rst_n, state_reg == BK_EMIT, (n_reg == 3'd3) || (n_reg == 3'd4), "bad polygon size")

endmodule

`default_nettype wire

// ----- rtl/triangle_near_clip_project_core.sv -----
// ----------------------------------------------------------------------------
// triangle_near_clip_project_core
// Near-plane clip of view-space triangles and perspective projection of the
// fan vertices that remain.
// ----------------------------------------------------------------------------
//   channel | signals                        | direction
//   vert    | vert_valid, vert_ready, vert   | in, one vertex a beat
//   pix     | pix_valid, pix_ready, pix      | out, one fan vertex a beat
//   cfg     | cfg_we, cfg_index, cfg_data    | in, write only
//
// Work: each divide runs on the single shared serial divider; a crossing
// costs 5 divides and each corner of the clipped polygon 3, then the fan
// vertices are emitted as beats.
// Reset: asynchronous rst_n clears control and loads register defaults.
// Stalls: a two-entry queue lets vertices keep arriving while a triangle is
// worked; a held pix beat stalls the emit sequence until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_near_clip_project_core
    import tnc_pkg::*;
#(
    parameter int QUEUE_DEPTH = TNC_QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   vert_valid,
    output logic                        vert_ready,
    input  wire vtx_in_t                vert,
    output logic                        pix_valid,
    input  wire logic                   pix_ready,
    output vtx_out_t                    pix
);

    logic [30:0] near_z_reg;
    logic [30:0] focal_reg;
    logic [11:0] left_reg;
    logic [11:0] top_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    cfg_t        cfg;
    logic        q_full;
    logic        q_push;
    tri_t        q_in;
    logic        q_valid;
    tri_t        q_head;
    logic        q_pop;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_z_reg <= 31'd65536;
            focal_reg  <= 31'd16777216;
            left_reg   <= 12'd0;
            top_reg    <= 12'd0;
            width_reg  <= 12'd320;
            height_reg <= 12'd240;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEAR_Z:       near_z_reg <= cfg_data;
                REG_FOCAL_LENGTH: focal_reg  <= cfg_data;
                REG_VIEW_LEFT:    left_reg   <= cfg_data[11:0];
                REG_VIEW_TOP:     top_reg    <= cfg_data[11:0];
                REG_VIEW_WIDTH:   width_reg  <= cfg_data[11:0];
                REG_VIEW_HEIGHT:  height_reg <= cfg_data[11:0];
                default:          ;
            endcase
        end
    end

    // Viewport centre in whole pixels
    always_comb
    begin
        cfg.near_z       = near_z_reg;
        cfg.focal_length = focal_reg;
        cfg.center_x     = {1'b0, left_reg} + {2'b00, width_reg[11:1]};
        cfg.center_y     = {1'b0, top_reg} + {2'b00, height_reg[11:1]};
    end

    tnc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    tnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    tnc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .head      (q_head),
        .q_pop     (q_pop),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule

`default_nettype wire
